// ===== hdl/vntm_pkg.sv =====
// ----------------------------------------------------------------------------
// vntm_pkg: shared types and constants of the voxel neighbour mask block
// Geometry record, ring store sizing, face bit positions and register indexes.
// ----------------------------------------------------------------------------
package vntm_pkg;

  localparam int DIM_W      = 6;
  localparam int COORD_W    = 5;
  localparam int MASK_W     = 6;
  localparam int MAX_DIM    = 32;
  localparam int RING_DEPTH = 4096;
  localparam int ADDR_W     = $clog2(RING_DEPTH);
  localparam int PLANE_W    = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int WORD_W     = 3;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(18);

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_DEPTH  = CFG_IDX_W'(2);

  localparam int FACE_PX = 0;
  localparam int FACE_NX = 1;
  localparam int FACE_PY = 2;
  localparam int FACE_NY = 3;
  localparam int FACE_PZ = 4;
  localparam int FACE_NZ = 5;

  // Effective grid size and the ring offsets that follow from it.
  typedef struct packed {
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [DIM_W-1:0]  d;
    logic [ADDR_W-1:0] off_px;
    logic [ADDR_W-1:0] off_py;
    logic [ADDR_W-1:0] off_ny;
    logic [ADDR_W-1:0] off_nz;
  } geom_t;

  // Ring store addresses of one request.
  typedef struct packed {
    logic [ADDR_W-1:0] wr;
    logic [ADDR_W-1:0] x_pair;
    logic [ADDR_W-1:0] py;
    logic [ADDR_W-1:0] ny;
    logic [ADDR_W-1:0] nz;
  } taps_t;

  // What is known about the described voxel when its request is taken.
  typedef struct packed {
    logic               emit;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] pos_z;
    logic               last;
    logic               pz;
  } vox_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== hdl/vntm_ram.sv =====
// ----------------------------------------------------------------------------
// vntm_ram: generic RAM with one write port and two registered read ports
// Read data changes only on a cycle in which that port is enabled.
// ----------------------------------------------------------------------------
module vntm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== hdl/vntm_cfg.sv =====
// ----------------------------------------------------------------------------
// vntm_cfg: grid size registers and derived ring offsets
// Holds the three size registers, clamps them and works out the tap offsets.
// ----------------------------------------------------------------------------
module vntm_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vntm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vntm_pkg::DIM_W-1:0]     cfg_data,
  output vntm_pkg::geom_t                geom,
  output logic                           settle
);
  import vntm_pkg::*;

  logic [DIM_W-1:0]   grid_width;
  logic [DIM_W-1:0]   grid_height;
  logic [DIM_W-1:0]   grid_depth;
  logic [DIM_W-1:0]   we_dim;
  logic [DIM_W-1:0]   he_dim;
  logic [PLANE_W-1:0] plane;
  geom_t              geom_next;
  logic               wr_fire;

  assign cfg_ready = 1'b1;
  assign wr_fire   = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= DIM_RESET;
      grid_height <= DIM_RESET;
      grid_depth  <= DIM_RESET;
    end else if (wr_fire) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        REG_GRID_DEPTH:  grid_depth  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign we_dim = eff_dim(grid_width);
  assign he_dim = eff_dim(grid_height);
  assign plane  = PLANE_W'(we_dim) * PLANE_W'(he_dim);

  always_comb begin
    geom_next.w      = we_dim;
    geom_next.h      = he_dim;
    geom_next.d      = eff_dim(grid_depth);
    geom_next.off_px = ADDR_W'(plane) - ADDR_W'(1);
    geom_next.off_py = ADDR_W'(plane) - ADDR_W'(we_dim);
    geom_next.off_ny = ADDR_W'(plane) + ADDR_W'(we_dim);
    geom_next.off_nz = ADDR_W'(plane) << 1;
  end

  // The derived geometry is registered after the size registers, so requests are
  // held off in the cycle after a write and after reset.
  always_ff @(posedge clk) begin
    geom <= geom_next;
    if (rst) begin
      settle <= 1'b1;
    end else begin
      settle <= wr_fire;
    end
  end

endmodule

// ===== hdl/vntm_scan.sv =====
// ----------------------------------------------------------------------------
// vntm_scan: raster position counters and ring address generation
// Tracks the write pointer and x, y, z of the arriving voxel, and forms the
// tap addresses and the description of the voxel one plane behind.
// ----------------------------------------------------------------------------
module vntm_scan (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          transparent,
  input  vntm_pkg::geom_t               geom,
  output vntm_pkg::taps_t               taps,
  output logic [vntm_pkg::WORD_W-1:0]   wr_word,
  output vntm_pkg::vox_t                vox
);
  import vntm_pkg::*;

  logic [ADDR_W-1:0]  write_pointer;
  logic [COORD_W-1:0] count_x;
  logic [COORD_W-1:0] count_y;
  logic [COORD_W-1:0] count_z;
  logic [COORD_W-1:0] count_x_next;
  logic [COORD_W-1:0] count_y_next;
  logic [COORD_W-1:0] count_z_next;
  logic               prev1;
  logic               prev2;
  logic [DIM_W-1:0]   x1, x2, y1, y2, z1;
  logic [ADDR_W-1:0]  behind;

  assign x1 = DIM_W'(count_x) + DIM_W'(1);
  assign x2 = DIM_W'(count_x) + DIM_W'(2);
  assign y1 = DIM_W'(count_y) + DIM_W'(1);
  assign y2 = DIM_W'(count_y) + DIM_W'(2);
  assign z1 = DIM_W'(count_z) + DIM_W'(1);

  // Each ring word holds the voxel at its address and the two before it, so
  // one read yields both x neighbours.
  assign wr_word = {prev2, prev1, transparent};

  assign behind      = write_pointer - geom.off_px;
  assign taps.wr     = write_pointer;
  assign taps.x_pair = behind;
  assign taps.py     = write_pointer - geom.off_py;
  assign taps.ny     = write_pointer - geom.off_ny;
  assign taps.nz     = write_pointer - geom.off_nz;

  always_comb begin
    vox.emit  = (count_x != '0) && (x2 <= geom.w) &&
                (count_y != '0) && (y2 <= geom.h) &&
                (count_z >= COORD_W'(2)) && (z1 <= geom.d);
    vox.pos_x = count_x;
    vox.pos_y = count_y;
    vox.pos_z = count_z - COORD_W'(1);
    vox.last  = (x2 == geom.w) && (y2 == geom.h) && (z1 == geom.d);
    vox.pz    = transparent;
  end

  always_comb begin
    count_x_next = count_x;
    count_y_next = count_y;
    count_z_next = count_z;
    if (x1 >= geom.w) begin
      count_x_next = '0;
      if (y1 >= geom.h) begin
        count_y_next = '0;
        count_z_next = (z1 >= geom.d) ? '0 : COORD_W'(z1);
      end else begin
        count_y_next = COORD_W'(y1);
      end
    end else begin
      count_x_next = COORD_W'(x1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      count_x       <= '0;
      count_y       <= '0;
      count_z       <= '0;
    end else if (accept) begin
      write_pointer <= write_pointer + ADDR_W'(1);
      count_x       <= count_x_next;
      count_y       <= count_y_next;
      count_z       <= count_z_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev1 <= transparent;
      prev2 <= prev1;
    end
  end

endmodule

// ===== hdl/voxel_neighbor_transparency_mask_top.sv =====
// ----------------------------------------------------------------------------
// voxel_neighbor_transparency_mask_top: six-neighbour transparency masks
// Voxel bits enter in raster order (x fastest, then y, then z). Each voxel's
// bit goes into a 4096-entry ring store, over two planes deep. When a voxel
// comes in, the voxel one plane behind it has five face neighbours stored and
// the arriving one as sixth; if interior, its 6-bit mask and coordinates leave.
// Channels: the input request carries transparent with in_valid/in_stall;
// results leave with out_valid/out_stall; grid_width, grid_height and
// grid_depth (indexes 0 to 2) are written over cfg_valid/cfg_ready.
// Throughput is one voxel per cycle while in_stall is low: the ring store is
// read through two RAMs with two read ports each, one port serving both x
// neighbours. Each result goes through the read stage to the output register.
// Border voxels give no result. Reset clears the position counters and the
// write pointer and sets all sizes to 18; the ring contents are not cleared.
// A configuration write holds off requests in the cycle after it, as does
// leaving reset. When the receiver
// stalls, the result waits in the output register, one more waits in the
// read stage, and in_stall rises only once both are full.
// ----------------------------------------------------------------------------
module voxel_neighbor_transparency_mask_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           transparent,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [vntm_pkg::MASK_W-1:0]    face_mask,
  output logic [vntm_pkg::COORD_W-1:0]   pos_x,
  output logic [vntm_pkg::COORD_W-1:0]   pos_y,
  output logic [vntm_pkg::COORD_W-1:0]   pos_z,
  output logic                           last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vntm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vntm_pkg::DIM_W-1:0]     cfg_data
);
  import vntm_pkg::*;

  geom_t             geom;
  taps_t             taps;
  vox_t              vox;
  vox_t              s1;
  logic              s1_valid;
  logic              s1_move;
  logic              settle;
  logic              accept;
  logic              rd_en;
  logic [WORD_W-1:0] wr_word;
  logic [WORD_W-1:0] x_word;
  logic [WORD_W-1:0] nz_word;
  logic              py_bit;
  logic              ny_bit;
  logic [MASK_W-1:0] mask;

  vntm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom),
    .settle    (settle)
  );

  vntm_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .transparent (transparent),
    .geom        (geom),
    .taps        (taps),
    .wr_word     (wr_word),
    .vox         (vox)
  );

  // Read stage is blocked only when it holds a result and the output
  // register cannot take it.
  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = settle || (s1_valid && !s1_move);
  assign accept   = in_valid && !in_stall;
  assign rd_en    = accept && vox.emit;

  vntm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RING_DEPTH)
  ) u_ram_xz (
    .clk     (clk),
    .we      (accept),
    .waddr   (taps.wr),
    .wdata   (wr_word),
    .re_a    (rd_en),
    .raddr_a (taps.x_pair),
    .rdata_a (x_word),
    .re_b    (rd_en),
    .raddr_b (taps.nz),
    .rdata_b (nz_word)
  );

  vntm_ram #(
    .WIDTH (1),
    .DEPTH (RING_DEPTH)
  ) u_ram_y (
    .clk     (clk),
    .we      (accept),
    .waddr   (taps.wr),
    .wdata   (wr_word[0]),
    .re_a    (rd_en),
    .raddr_a (taps.py),
    .rdata_a (py_bit),
    .re_b    (rd_en),
    .raddr_b (taps.ny),
    .rdata_b (ny_bit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= vox.emit;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= vox;
    end
  end

  always_comb begin
    mask          = '0;
    mask[FACE_PX] = x_word[0];
    mask[FACE_NX] = x_word[2];
    mask[FACE_PY] = py_bit;
    mask[FACE_NY] = ny_bit;
    mask[FACE_PZ] = s1.pz;
    mask[FACE_NZ] = nz_word[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      face_mask <= mask;
      pos_x     <= s1.pos_x;
      pos_y     <= s1.pos_y;
      pos_z     <= s1.pos_z;
      last      <= s1.last;
    end
  end

`ifndef NO_ASSERTIONS
  a_interlock: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |-> in_stall)
    else $error("request taken while the read stage was blocked");

  a_cfg_settle: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> in_stall)
    else $error("request taken before the geometry settled");

  a_interior: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pos_x != '0 && pos_y != '0 && pos_z != '0)
    else $error("border voxel reached the output");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> (DIM_W'(pos_x) + DIM_W'(2) == geom.w) &&
                          (DIM_W'(pos_y) + DIM_W'(2) == geom.h))
    else $error("last flag on a voxel that is not the final interior one");
`endif

endmodule
